// File: src/gn2d_pkg.sv
// ---------------------------------------------------------------------------
// gn2d_pkg: shared types and constants for the 2D gradient noise block
// Sequencer states, register indexes and fixed-point constants.
// ---------------------------------------------------------------------------
package gn2d_pkg;

  // configuration register indexes
  localparam logic CFG_CELL_SIZE   = 1'b0;
  localparam logic CFG_GRID_RADIUS = 1'b1;

  // input opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  // gradient used for corners outside the table: (1.0, 0) in Q1.14
  localparam logic signed [15:0] DEFAULT_GX = 16'sd16384;
  localparam logic signed [15:0] DEFAULT_GY = 16'sd0;

  localparam int DIV_STEPS = 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_MAG,
    ST_DIV_MAG_WAIT,
    ST_DIV_FRAC,
    ST_DIV_FRAC_WAIT,
    ST_CORNER_ADDR,
    ST_CORNER_READ,
    ST_MUL_X,
    ST_MUL_Y,
    ST_MUL_ACC,
    ST_BLEND_SUB,
    ST_BLEND_MUL,
    ST_BLEND_ADD,
    ST_DONE
  } gn2d_state_t;

  // divider handshake
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } gn2d_div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
    logic [15:0] remainder;
  } gn2d_div_rsp_t;

endpackage

// File: src/gradient_noise_2d_top.sv
// ---------------------------------------------------------------------------
// gradient_noise_2d_top: 2D gradient noise with a loadable gradient table
// Write words store one Q1.14 gradient; evaluate words return one Q1.14 value.
// ---------------------------------------------------------------------------
// A write word is taken while the block is idle. An evaluate word makes
// four passes of the 32-step serial divider (integer and fraction split of
// each axis), then for each corner the table read and two products on the
// shared multiplier, then the three blends and the load of the output
// register. in_stall is high for the whole evaluation; a finished value
// waits in the output register while the next word is taken. The gradient
// table holds garbage until written.
module gradient_noise_2d_top
  import gn2d_pkg::*;
#(
  parameter int TABLE_DEPTH = 4096,
  parameter int MAX_RADIUS  = 31
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               opcode,
  input  logic [11:0]        entry_index,
  input  logic signed [15:0] grad_x,
  input  logic signed [15:0] grad_y,
  input  logic signed [23:0] pos_x,
  input  logic signed [23:0] pos_y,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] noise_value
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  gn2d_state_t state, state_next;

  logic [15:0] cell_size;
  logic [4:0]  grid_radius;

  logic signed [23:0] px, py;
  logic               axis;
  logic signed [25:0] qx, qy;
  logic [15:0]        fx, fy;
  logic               neg;
  logic [15:0]        rpart;
  logic [1:0]         corner;
  logic [1:0]         bsel;

  logic [31:0]        mem [TABLE_DEPTH];
  logic [31:0]        rd_data;
  logic [AW-1:0]      rd_addr;
  logic               oob;

  logic signed [35:0] d [4];
  logic signed [35:0] acc;
  logic signed [35:0] diff;
  logic signed [53:0] prod;
  logic signed [35:0] ma;
  logic signed [17:0] mb;

  gn2d_div_req_t div_req;
  gn2d_div_rsp_t div_rsp;

  logic        in_take;
  logic        out_free;
  logic [15:0] csz;
  logic [4:0]  rad;

  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign csz      = (cell_size == 16'd0) ? 16'd1 : cell_size;
  assign rad      = (32'(grid_radius) > MAX_RADIUS) ? 5'(MAX_RADIUS) : grid_radius;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_size   <= 16'd16;
      grid_radius <= 5'd31;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CELL_SIZE:   cell_size   <= cfg_data;
        CFG_GRID_RADIUS: grid_radius <= cfg_data[4:0];
        default:         ;
      endcase
    end
  end

  // gradient table
  logic [16:0] wr_ext;
  assign wr_ext = {5'd0, entry_index};

  always_ff @(posedge clk) begin
    if (in_take && opcode == OP_WRITE && 32'(entry_index) < TABLE_DEPTH)
      mem[wr_ext[AW-1:0]] <= {grad_y, grad_x};
    if (state == ST_CORNER_READ)
      rd_data <= mem[rd_addr];
  end

  gn2d_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:          if (in_take && opcode == OP_EVAL) state_next = ST_DIV_MAG;
      ST_DIV_MAG:       state_next = ST_DIV_MAG_WAIT;
      ST_DIV_MAG_WAIT:  if (div_rsp.done) state_next = ST_DIV_FRAC;
      ST_DIV_FRAC:      state_next = ST_DIV_FRAC_WAIT;
      ST_DIV_FRAC_WAIT: if (div_rsp.done) state_next = axis ? ST_CORNER_ADDR : ST_DIV_MAG;
      ST_CORNER_ADDR:   state_next = ST_CORNER_READ;
      ST_CORNER_READ:   state_next = ST_MUL_X;
      ST_MUL_X:         state_next = ST_MUL_Y;
      ST_MUL_Y:         state_next = ST_MUL_ACC;
      ST_MUL_ACC:       state_next = (corner == 2'd3) ? ST_BLEND_SUB : ST_CORNER_ADDR;
      ST_BLEND_SUB:     state_next = ST_BLEND_MUL;
      ST_BLEND_MUL:     state_next = ST_BLEND_ADD;
      ST_BLEND_ADD:     state_next = (bsel == 2'd2) ? ST_DONE : ST_BLEND_SUB;
      ST_DONE:          if (out_free) state_next = ST_IDLE;
      default:          state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // control outputs
  logic [23:0] pmag;
  logic signed [23:0] pcur;
  assign pcur = axis ? py : px;
  assign pmag = pcur[23] ? 24'(-pcur) : pcur;

  always_comb begin
    in_stall         = (state != ST_IDLE);
    div_req.start    = 1'b0;
    div_req.divisor  = csz;
    div_req.dividend = {8'd0, pmag};
    unique case (state)
      ST_DIV_MAG:  div_req.start = 1'b1;
      ST_DIV_FRAC: begin
        div_req.start    = 1'b1;
        div_req.dividend = {rpart, 16'd0};
      end
      default: ;
    endcase
  end

  // corner address and range check
  logic               kx, ky;
  logic signed [25:0] cx, cy, rr;
  logic               in_grid;
  logic [5:0]         ux, uy;
  logic [11:0]        cidx;
  logic [15:0]        cidx_ext;
  assign kx = corner[1];
  assign ky = corner[0];

  always_comb begin
    cx       = qx + 26'(kx);
    cy       = qy + 26'(ky);
    rr       = 26'(rad);
    in_grid  = (cx >= -rr) && (cx <= rr) && (cy >= -rr) && (cy <= rr);
    ux       = cx[5:0] + {1'b0, rad};
    uy       = cy[5:0] + {1'b0, rad};
    cidx     = 12'(ux) * 12'({rad, 1'b1}) + 12'(uy);
    cidx_ext = {4'd0, cidx};
  end

  // shared multiplier operands
  logic signed [15:0] gx, gy;
  logic signed [17:0] ox, oy;
  logic [15:0]        tcur;
  assign gx   = oob ? DEFAULT_GX : rd_data[15:0];
  assign gy   = oob ? DEFAULT_GY : rd_data[31:16];
  assign ox   = $signed({2'b00, fx}) - (kx ? 18'sd65536 : 18'sd0);
  assign oy   = $signed({2'b00, fy}) - (ky ? 18'sd65536 : 18'sd0);
  assign tcur = (bsel == 2'd2) ? fx : fy;

  always_comb begin
    ma = 36'(gx);
    mb = ox;
    unique case (state)
      ST_MUL_Y: begin
        ma = 36'(gy);
        mb = oy;
      end
      ST_BLEND_MUL: begin
        ma = diff;
        mb = $signed({2'b00, tcur});
      end
      default: ;
    endcase
  end

  // blend operand pick
  logic signed [35:0] ba, bb;
  always_comb begin
    unique case (bsel)
      2'd0:    begin ba = d[0]; bb = d[1]; end
      2'd1:    begin ba = d[2]; bb = d[3]; end
      default: begin ba = d[0]; bb = d[2]; end
    endcase
  end

  // rounding and saturation of the final value
  logic signed [36:0] vround;
  logic signed [20:0] vq;
  logic signed [15:0] vsat;
  always_comb begin
    vround = 37'(d[0]) + 37'sd32768;
    vq     = 21'(vround >>> 16);
    if (vq > 21'sd32767)       vsat = 16'sd32767;
    else if (vq < -21'sd32768) vsat = -16'sd32768;
    else                       vsat = vq[15:0];
  end

  // datapath
  logic [15:0] qlo;
  logic signed [25:0] qe, qfix;
  assign qe   = {1'b0, div_rsp.quotient[24:0]};
  assign qfix = !neg ? qe : ((div_rsp.remainder != 16'd0) ? ~qe : -qe);
  assign qlo  = div_rsp.quotient[15:0];

  always_ff @(posedge clk) begin
    if (in_take && opcode == OP_EVAL) begin
      px     <= pos_x;
      py     <= pos_y;
      axis   <= 1'b0;
      corner <= 2'd0;
      bsel   <= 2'd0;
    end
    unique case (state)
      ST_DIV_MAG: neg <= pcur[23];
      ST_DIV_MAG_WAIT: if (div_rsp.done) begin
        if (axis) qy <= qfix;
        else      qx <= qfix;
        rpart <= (neg && div_rsp.remainder != 16'd0) ? csz - div_rsp.remainder
                                                      : div_rsp.remainder;
      end
      ST_DIV_FRAC_WAIT: if (div_rsp.done) begin
        if (axis) fy <= qlo;
        else      fx <= qlo;
        axis <= 1'b1;
      end
      ST_CORNER_ADDR: begin
        oob     <= !in_grid || (32'(cidx) >= TABLE_DEPTH);
        rd_addr <= cidx_ext[AW-1:0];
      end
      ST_MUL_X: prod <= ma * mb;
      ST_MUL_Y: begin
        prod <= ma * mb;
        acc  <= 36'(prod);
      end
      ST_MUL_ACC: begin
        d[corner] <= acc + 36'(prod);
        corner    <= corner + 2'd1;
      end
      ST_BLEND_SUB: diff <= bb - ba;
      ST_BLEND_MUL: prod <= ma * mb;
      ST_BLEND_ADD: begin
        if (bsel == 2'd1) d[2] <= ba + 36'(prod >>> 16);
        else              d[0] <= ba + 36'(prod >>> 16);
        bsel <= bsel + 2'd1;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (state == ST_DONE && out_free) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) noise_value <= vsat;
  end

endmodule

// File: src/gn2d_div.sv
// ---------------------------------------------------------------------------
// gn2d_div: serial unsigned divider
// Restoring division of a 32-bit dividend by a 16-bit divisor, one quotient
// bit per cycle. done is high for a single cycle once the last step is registered; results hold.
// ---------------------------------------------------------------------------
module gn2d_div
  import gn2d_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  gn2d_div_req_t req,
  output gn2d_div_rsp_t rsp
);

  logic        busy;
  logic        finished;
  logic [5:0]  count;
  logic [31:0] dvd;
  logic [31:0] quo;
  logic [16:0] rem;
  logic [15:0] dsr;
  logic [16:0] rem_shift;
  logic [16:0] rem_diff;
  logic        fits;

  // one restoring step
  always_comb begin
    rem_shift = {rem[15:0], dvd[31]};
    rem_diff  = rem_shift - {1'b0, dsr};
    fits      = rem_shift >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      count    <= '0;
      finished <= 1'b0;
    end else begin
      finished <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 6'd1;
        if (count == 6'(DIV_STEPS - 1)) begin
          busy     <= 1'b0;
          finished <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dsr <= req.divisor;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      dvd <= {dvd[30:0], 1'b0};
      quo <= {quo[30:0], fits};
      rem <= fits ? rem_diff : rem_shift;
    end
  end

  assign rsp = '{done: finished, quotient: quo, remainder: rem[15:0]};

endmodule
